FILE: hw/rtl/wvfc_pkg.sv
`timescale 1ns / 1ps
package wvfc_pkg;

    localparam int XW = 37;
    localparam logic [29:0] INVK_Q30 = 30'd652032874;

    function automatic logic [23:0] atan_entry(input int idx);
        logic [23:0] t;
        case (idx)
            0:  t = 24'd2097152;
            1:  t = 24'd1238021;
            2:  t = 24'd654136;
            3:  t = 24'd332050;
            4:  t = 24'd166669;
            5:  t = 24'd83416;
            6:  t = 24'd41718;
            7:  t = 24'd20860;
            8:  t = 24'd10430;
            9:  t = 24'd5215;
            10: t = 24'd2608;
            11: t = 24'd1304;
            12: t = 24'd652;
            13: t = 24'd326;
            14: t = 24'd163;
            15: t = 24'd81;
            16: t = 24'd41;
            17: t = 24'd20;
            18: t = 24'd10;
            19: t = 24'd5;
            20: t = 24'd3;
            21: t = 24'd1;
            22: t = 24'd1;
            default: t = 24'd0;
        endcase
        return t;
    endfunction

    // atan(2^-idx) rounded half up to ab-bit binary angle
    function automatic logic [23:0] stage_ang(input int idx, input int ab);
        logic [24:0] t;
        int          s;
        s = 24 - ab;
        t = {1'b0, atan_entry(idx)};
        if (s > 0) begin
            t = (t + (25'd1 << (s - 1))) >> s;
        end
        return t[23:0];
    endfunction

endpackage

FILE: hw/rtl/wvfc_cordic_cell.sv
`timescale 1ns / 1ps
module wvfc_cordic_cell
    import wvfc_pkg::*;
#(
    parameter int STAGE  = 0,
    parameter int AW     = 16,
    parameter int ZW     = 18,
    parameter bit ROTATE = 1'b1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic        [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic        [ZW-1:0] o_z
);

    localparam logic [23:0]   A24 = stage_ang(STAGE, AW);
    localparam logic [ZW-1:0] A   = ZW'(A24);

    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic                 neg;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic        [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic        [ZW-1:0] r_z;

    always_comb begin
        dx  = i_y >>> STAGE;
        dy  = i_x >>> STAGE;
        neg = ROTATE ? i_z[ZW-1] : ~i_y[XW-1];
        if (neg) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + A;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hw/rtl/wvfc_mag_scale.sv
`timescale 1ns / 1ps
module wvfc_mag_scale
    import wvfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    output logic        [15:0]   o_mag
);

    localparam int HW = XW - 18;

    logic [46:0]    n_plo;
    logic [HW+29:0] n_phi;
    logic [46:0]    r_plo;
    logic [HW+29:0] r_phi;
    logic [67:0]    sum;
    logic [15:0]    n_mag;
    logic [15:0]    r_mag;

    // x is non-negative here; split into two partial products
    always_comb begin
        n_plo = 47'(i_x[16:0]) * 47'(INVK_Q30);
        n_phi = (HW+30)'(i_x[XW-2:17]) * (HW+30)'(INVK_Q30);
        sum   = (68'(r_phi) << 17) + 68'(r_plo) + (68'd1 << 45);
        n_mag = (|sum[67:62]) ? 16'hFFFF : sum[61:46];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

FILE: hw/rtl/wind_vector_frame_converter.sv
`timescale 1ns / 1ps
// Apparent/true wind converter. One request per cycle is accepted whenever the output
// side is not stalled; each request passes through the prep stages, a chain of CORDIC
// rotation cells, velocity add, vectoring start, a chain of CORDIC vectoring cells, the
// two-step magnitude scaling and the output register. tuser in: bit 0 req_type, bit 1
// velocity_valid. A stall at the output holds the whole pipeline.
module wind_vector_frame_converter
    import wvfc_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // wind_dir, wind_speed, vehicle_yaw, vel_north, vel_east
    input  logic [79:0] i_s_tdata,
    // req_type, velocity_valid
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_dir, out_speed
    output logic [31:0] o_m_tdata,
    // updated
    output logic [0:0]  o_m_tuser
);

    localparam int AW  = ANGLE_BITS;
    localparam int N   = CORDIC_STAGES;
    localparam int ZR  = AW + 2;
    localparam int UPS = (AW > 16) ? AW - 16 : 0;
    localparam int DNS = (AW < 16) ? 16 - AW : 0;
    localparam int L   = 2 * N + 7;
    localparam int SVB = N + 3;
    localparam logic [AW-1:0]        AHALF = AW'(2 ** (AW - 1));
    localparam logic signed [ZR-1:0] ZQ    = ZR'(2 ** (AW - 2));
    localparam logic signed [ZR-1:0] ZH    = ZR'(2 ** (AW - 1));
    localparam logic [31:0]          RND   = (UPS > 0) ? 32'(2 ** (UPS - 1)) : 32'd0;

    logic en;
    logic r_vld [L];
    logic          r_mode [L-1];
    logic          r_vv   [L-1];
    logic [AW-1:0] r_yaw  [L-1];
    logic [31:0]   r_pass [L-1];
    logic [31:0]   r_vel  [N+2];
    logic          r_zero [SVB:L-2];

    // prep
    logic [39:0]   dir_w;
    logic [39:0]   yaw_w;
    logic [AW-1:0] dir_b;
    logic [AW-1:0] yaw_b;
    logic [AW-1:0] n_theta;
    logic [45:0]   prod;
    logic [AW-1:0] r_theta;
    logic [31:0]   r_xs;
    logic signed [ZR-1:0] zs;
    logic signed [XW-1:0] xs_ext;
    logic signed [XW-1:0] n_x0;
    logic signed [ZR-1:0] n_z0;
    logic signed [XW-1:0] r_x0;
    logic signed [ZR-1:0] r_z0;

    logic signed [XW-1:0] w_rx [N+1];
    logic signed [XW-1:0] w_ry [N+1];
    logic        [ZR-1:0] w_rz [N+1];

    // velocity add and vectoring start
    logic signed [XW-1:0] vn_s;
    logic signed [XW-1:0] ve_s;
    logic signed [XW-1:0] r_va_x;
    logic signed [XW-1:0] r_va_y;
    logic                 zero_c;
    logic signed [XW-1:0] r_vb_x;
    logic signed [XW-1:0] r_vb_y;
    logic        [AW-1:0] r_vb_z;

    logic signed [XW-1:0] w_vx [N+1];
    logic signed [XW-1:0] w_vy [N+1];
    logic        [AW-1:0] w_vz [N+1];

    logic [AW-1:0] r_ang1;
    logic [AW-1:0] r_ang2;
    logic [15:0]   mag;

    // output
    logic [AW-1:0] ang_v;
    logic [AW-1:0] ang_a;
    logic [31:0]   fb;
    logic [31:0]   n_tdata;
    logic          n_upd;
    logic [31:0]   r_tdata;
    logic          r_upd;

    assign en         = ~r_vld[L-1] | i_m_tready;
    assign o_s_tready = en;

    always_comb begin
        dir_w   = ({24'd0, i_s_tdata[15:0]} << UPS) >> DNS;
        yaw_w   = ({24'd0, i_s_tdata[47:32]} << UPS) >> DNS;
        dir_b   = dir_w[AW-1:0];
        yaw_b   = yaw_w[AW-1:0];
        n_theta = i_s_tuser[0] ? dir_b + AHALF : dir_b + yaw_b + AHALF;
        prod    = 46'(i_s_tdata[31:16]) * 46'(INVK_Q30) + 46'd8192;
    end

    always_comb begin
        zs     = ZR'($signed(r_theta));
        xs_ext = XW'(r_xs);
        if (zs > ZQ) begin
            n_z0 = zs - ZH;
            n_x0 = -xs_ext;
        end else if (zs < -ZQ) begin
            n_z0 = zs + ZH;
            n_x0 = -xs_ext;
        end else begin
            n_z0 = zs;
            n_x0 = xs_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_theta <= n_theta;
            r_xs    <= prod[45:14];
            r_x0    <= n_x0;
            r_z0    <= n_z0;
        end
    end

    assign w_rx[0] = r_x0;
    assign w_ry[0] = '0;
    assign w_rz[0] = r_z0;

    for (genvar k = 0; k < N; k++) begin : g_rot
        wvfc_cordic_cell #(
            .STAGE (k),
            .AW    (AW),
            .ZW    (ZR),
            .ROTATE(1'b1)
        ) u_cell (
            .i_clk(i_clk),
            .i_en (en),
            .i_x  (w_rx[k]),
            .i_y  (w_ry[k]),
            .i_z  (w_rz[k]),
            .o_x  (w_rx[k+1]),
            .o_y  (w_ry[k+1]),
            .o_z  (w_rz[k+1])
        );
    end

    always_comb begin
        vn_s   = {{(XW-32){r_vel[N+1][15]}}, r_vel[N+1][15:0], 16'd0};
        ve_s   = {{(XW-32){r_vel[N+1][31]}}, r_vel[N+1][31:16], 16'd0};
        zero_c = (r_va_x == '0) && (r_va_y == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_mode[N+1]) begin
                r_va_x <= w_rx[N] - vn_s;
                r_va_y <= w_ry[N] - ve_s;
            end else begin
                r_va_x <= w_rx[N] + vn_s;
                r_va_y <= w_ry[N] + ve_s;
            end
            if (r_va_x[XW-1]) begin
                r_vb_x <= -r_va_x;
                r_vb_y <= -r_va_y;
                r_vb_z <= AHALF;
            end else begin
                r_vb_x <= r_va_x;
                r_vb_y <= r_va_y;
                r_vb_z <= '0;
            end
        end
    end

    assign w_vx[0] = r_vb_x;
    assign w_vy[0] = r_vb_y;
    assign w_vz[0] = r_vb_z;

    for (genvar k = 0; k < N; k++) begin : g_vec
        wvfc_cordic_cell #(
            .STAGE (k),
            .AW    (AW),
            .ZW    (AW),
            .ROTATE(1'b0)
        ) u_cell (
            .i_clk(i_clk),
            .i_en (en),
            .i_x  (w_vx[k]),
            .i_y  (w_vy[k]),
            .i_z  (w_vz[k]),
            .o_x  (w_vx[k+1]),
            .o_y  (w_vy[k+1]),
            .o_z  (w_vz[k+1])
        );
    end

    wvfc_mag_scale u_mag (
        .i_clk(i_clk),
        .i_en (en),
        .i_x  (w_vx[N]),
        .o_mag(mag)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang1 <= w_vz[N];
            r_ang2 <= r_ang1;
        end
    end

    // side data shift lines
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mode[0] <= i_s_tuser[0];
            r_vv[0]   <= i_s_tuser[1];
            r_yaw[0]  <= yaw_b;
            r_pass[0] <= i_s_tdata[31:0];
            r_vel[0]  <= i_s_tdata[79:48];
            for (int k = 1; k < L - 1; k++) begin
                r_mode[k] <= r_mode[k-1];
                r_vv[k]   <= r_vv[k-1];
                r_yaw[k]  <= r_yaw[k-1];
                r_pass[k] <= r_pass[k-1];
            end
            for (int k = 1; k < N + 2; k++) begin
                r_vel[k] <= r_vel[k-1];
            end
            r_zero[SVB] <= zero_c;
            for (int k = SVB + 1; k < L - 1; k++) begin
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        ang_v = r_zero[L-2] ? '0 : r_ang2;
        ang_a = ang_v - AHALF - (r_mode[L-2] ? r_yaw[L-2] : '0);
        fb    = ((32'(ang_a) << DNS) + RND) >> UPS;
        if (!r_vv[L-2]) begin
            n_tdata = r_mode[L-2] ? 32'd0 : r_pass[L-2];
            n_upd   = ~r_mode[L-2];
        end else begin
            n_tdata = {mag, fb[15:0]};
            n_upd   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= n_tdata;
            r_upd   <= n_upd;
        end
    end

    assign o_m_tvalid   = r_vld[L-1];
    assign o_m_tdata    = r_tdata;
    assign o_m_tuser[0] = r_upd;

endmodule

FILE: hw/rtl/wvfc_checker.sv
`timescale 1ns / 1ps
module wvfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output request changed while stalled");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted during output stall");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready with empty output");

    a_no_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 32'd0)
        else $error("non-updated result carries data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind wind_vector_frame_converter wvfc_checker u_wvfc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
